>>> rtl/core/tmts_pkg.sv
// Shared types and constants of the tempo-map tick-to-seconds converter.
// Item structs, controller states, datapath commands and status.
// No dependencies.
package tmts_pkg;

    // Default sizing
    localparam int DEF_TEMPO_ENTRIES = 64;
    localparam int DEF_FRACTION_BITS = 16;

    // Field widths
    localparam int TICK_W     = 32;
    localparam int BPM_W      = 10;
    localparam int TPQ_W      = 11;
    localparam int USED_W     = 7;
    localparam int NOTE_W     = 16;
    localparam int DUR_W      = 32;
    localparam int PROD60_W   = 22;                 // 60 * 65535 fits in 22 bits
    localparam int DEN_W      = BPM_W + TPQ_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TPQ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USED  = 2'd2;

    // Reset values and fixed constants
    localparam logic [TPQ_W-1:0]    RESET_TPQ   = 11'd480;
    localparam logic [BPM_W-1:0]    RESET_TEMPO = 10'd120;
    localparam logic [PROD60_W-1:0] SEC_PER_MIN = 22'd60;

    typedef struct packed {
        logic              mode;
        logic              first_of_track;
        logic [3:0]        channel;
        logic [5:0]        entry_index;
        logic [TICK_W-1:0] entry_tick;
        logic [BPM_W-1:0]  entry_tempo;
        logic [NOTE_W-1:0] note_ticks;
        logic signed [7:0] tone;
        logic [6:0]        volume;
        logic [15:0]       word_handle;
    } t_in_item;

    typedef struct packed {
        logic [3:0]       out_channel;
        logic             is_pause;
        logic [6:0]       out_tone;
        logic [6:0]       out_volume;
        logic [15:0]      out_word_handle;
        logic [DUR_W-1:0] duration;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RESTART,
        ST_ROW0,
        ST_ROW1,
        ST_CHECK,
        ST_LOOP,
        ST_ADV,
        ST_ADV_CHK,
        ST_TICK,
        ST_DIV,
        ST_ACC,
        ST_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LATCH,
        OP_RESTART,
        OP_TAKE_BPM,
        OP_TAKE_TICK,
        OP_ADVANCE,
        OP_SEG_ALL,
        OP_SEG_PART,
        OP_DIV,
        OP_ACC,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   rd_en;      // read a table row
        logic   rd_zero;    // row 0 instead of the next-entry row
        logic   clr_pend;   // no further tempo change pending
    } t_dp_cmd;

    typedef struct packed {
        logic used_zero;
        logic used_gt1;
        logic nei_ge_used;
        logic pending;
        logic crossing;     // rest of the note passes the next change tick
        logic reached;      // position at or past the next change tick
        logic div_last;
    } t_dp_stat;

endpackage

>>> rtl/core/tmts_dp.sv
// Datapath of the tick-to-seconds converter: tempo table, walk state,
// segment divider, total accumulator and result register. Uses tmts_pkg.
module tmts_dp import tmts_pkg::*; #(
    parameter int TEMPO_ENTRIES = DEF_TEMPO_ENTRIES,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_item              i_in_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output t_out_item             o_out_item
);

    localparam int AW    = $clog2(TEMPO_ENTRIES);
    localparam int UW    = $clog2(TEMPO_ENTRIES + 1);
    localparam int NW    = PROD60_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(NW);
    localparam int ROW_W = TICK_W + BPM_W;

    // Configuration
    logic [TPQ_W-1:0]  r_cfg_tpq;
    logic [BPM_W-1:0]  r_cfg_tempo;
    logic [USED_W-1:0] r_cfg_used;

    // Walk state
    logic [TICK_W-1:0] r_pos;
    logic [BPM_W-1:0]  r_tempo;
    logic [UW-1:0]     r_nei;
    logic [TICK_W-1:0] r_nct;
    logic              r_pending;

    // Per-note working registers
    t_in_item          r_note;
    logic [TICK_W:0]   r_now;
    logic [NOTE_W-1:0] r_rem;
    logic [NOTE_W-1:0] r_seg;
    logic [DUR_W-1:0]  r_total;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_prem;
    logic [NW-1:0]     r_quo;
    logic [CNT_W-1:0]  r_div_cnt;
    t_out_item         r_out;

    // Tempo table
    logic [ROW_W-1:0]  r_mem [TEMPO_ENTRIES];
    logic [ROW_W-1:0]  r_rd;

    logic [UW-1:0]       used;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic                wr_ok;
    logic [TICK_W+1:0]   end_pos;
    logic                crossing;
    logic                reached;
    logic                div_last;
    logic [NOTE_W-1:0]   part;
    logic [NOTE_W-1:0]   seg_ticks;
    logic [BPM_W-1:0]    bpm_eff;
    logic [TPQ_W-1:0]    tpq_eff;
    logic [PROD60_W-1:0] num60;
    logic [DEN_W:0]      p_shift;
    logic                q_bit;
    logic [63:0]         q_wide;
    logic [DUR_W-1:0]    seg_sat;
    logic [DUR_W:0]      t_sum;
    logic                pause;

    // Clamp the entry count to the table depth
    assign used = (32'(r_cfg_used) > 32'(TEMPO_ENTRIES)) ? UW'(TEMPO_ENTRIES)
                                                         : UW'(r_cfg_used);
    assign rd_addr = i_cmd.rd_zero ? '0 : r_nei[AW-1:0];
    assign wr_addr = AW'(i_in_item.entry_index);
    assign wr_ok   = 32'(i_in_item.entry_index) < 32'(TEMPO_ENTRIES);

    // Compare the position against the next change tick, unwrapped
    assign end_pos  = (TICK_W+2)'(r_now) + (TICK_W+2)'(r_rem);
    assign crossing = end_pos > (TICK_W+2)'(r_nct);
    assign reached  = (TICK_W+2)'(r_now) >= (TICK_W+2)'(r_nct);
    assign div_last = r_div_cnt == CNT_W'(NW - 1);

    assign o_stat = '{
        used_zero:   used == '0,
        used_gt1:    used > UW'(1),
        nei_ge_used: r_nei >= used,
        pending:     r_pending,
        crossing:    crossing,
        reached:     reached,
        div_last:    div_last
    };

    // Segment operands: ticks, zero divisors taken as one
    assign part      = NOTE_W'(r_nct - r_now[TICK_W-1:0]);
    assign seg_ticks = (i_cmd.op == OP_SEG_PART) ? part : r_rem;
    assign bpm_eff   = (r_tempo == '0) ? BPM_W'(1) : r_tempo;
    assign tpq_eff   = (r_cfg_tpq == '0) ? TPQ_W'(1) : r_cfg_tpq;
    assign num60     = PROD60_W'(seg_ticks) * SEC_PER_MIN;

    // One restoring division step
    assign p_shift = {r_prem, r_quo[NW-1]};
    assign q_bit   = p_shift >= {1'b0, r_den};

    // Saturate the segment, then the running total
    assign q_wide  = 64'(r_quo);
    assign seg_sat = (|q_wide[63:32]) ? '1 : q_wide[31:0];
    assign t_sum   = {1'b0, r_total} + {1'b0, seg_sat};

    assign pause = r_note.tone[7];

    // Write configuration and advance the tempo walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_tpq   <= RESET_TPQ;
            r_cfg_tempo <= RESET_TEMPO;
            r_cfg_used  <= '0;
            r_pos       <= '0;
            r_tempo     <= RESET_TEMPO;
            r_nei       <= UW'(1);
            r_nct       <= '0;
            r_pending   <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TPQ:   r_cfg_tpq   <= i_cfg_data[TPQ_W-1:0];
                    CFG_TEMPO: r_cfg_tempo <= i_cfg_data[BPM_W-1:0];
                    CFG_USED:  r_cfg_used  <= i_cfg_data[USED_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_pend) begin
                r_pending <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_RESTART: begin
                    r_pos     <= '0;
                    r_nei     <= UW'(1);
                    r_pending <= 1'b0;
                    r_tempo   <= r_cfg_tempo;
                end
                OP_TAKE_BPM:  r_tempo <= r_rd[BPM_W-1:0];
                OP_TAKE_TICK: begin
                    r_nct     <= r_rd[ROW_W-1:BPM_W];
                    r_pending <= 1'b1;
                end
                OP_ADVANCE: begin
                    r_tempo <= r_rd[BPM_W-1:0];
                    r_nei   <= r_nei + UW'(1);
                end
                OP_SEG_ALL, OP_SEG_PART: r_div_cnt <= '0;
                OP_DIV:    r_div_cnt <= r_div_cnt + CNT_W'(1);
                OP_FINISH: r_pos     <= r_now[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold note fields, run segments and form the result
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LATCH: begin
                r_note  <= i_in_item;
                r_now   <= {1'b0, r_pos};
                r_rem   <= i_in_item.note_ticks;
                r_total <= '0;
            end
            OP_RESTART: r_now <= '0;
            OP_SEG_ALL, OP_SEG_PART: begin
                r_seg  <= seg_ticks;
                r_den  <= DEN_W'(bpm_eff) * DEN_W'(tpq_eff);
                r_prem <= '0;
                r_quo  <= {num60, {FRACTION_BITS{1'b0}}};
            end
            OP_DIV: begin
                r_prem <= q_bit ? DEN_W'(p_shift - {1'b0, r_den}) : DEN_W'(p_shift);
                r_quo  <= {r_quo[NW-2:0], q_bit};
            end
            OP_ACC: begin
                r_total <= t_sum[DUR_W] ? '1 : t_sum[DUR_W-1:0];
                r_now   <= r_now + (TICK_W+1)'(r_seg);
                r_rem   <= r_rem - r_seg;
            end
            OP_FINISH: begin
                r_out.out_channel     <= r_note.channel;
                r_out.is_pause        <= pause;
                r_out.out_tone        <= pause ? 7'd0 : r_note.tone[6:0];
                r_out.out_volume      <= pause ? 7'd0 : r_note.volume;
                r_out.out_word_handle <= pause ? 16'd0 : r_note.word_handle;
                r_out.duration        <= r_total;
            end
            default: ;
        endcase
    end

    // Tempo table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && wr_ok) begin
            r_mem[wr_addr] <= {i_in_item.entry_tick, i_in_item.entry_tempo};
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign o_out_item = r_out;

    // The walk never points past the table
    a_nei_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_nei) <= 32'(TEMPO_ENTRIES))
        else $error("next entry index beyond the tempo table");

    // A segment never takes more ticks than remain in the note
    a_seg_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_ACC) |-> (r_seg <= r_rem))
        else $error("segment longer than the remaining ticks");

    // A partial segment only where the note crosses a pending change
    a_part_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SEG_PART) |-> (r_pending && crossing && !reached))
        else $error("partial segment without a crossing");

    // Accumulate only right after the last division step
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_ACC) |-> $past(i_cmd.op == OP_DIV && div_last))
        else $error("accumulate before the division finished");

endmodule

>>> rtl/core/tmts_ctrl.sv
// Controller of the tick-to-seconds converter: handshakes, tempo walk
// sequencing and segment scheduling. Uses tmts_pkg; drives tmts_dp.
module tmts_ctrl import tmts_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_mode,
    input  logic     i_first,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_final, n_final;
    logic   r_out_valid, n_out_valid;
    logic   finish;

    // Hold state, segment flag and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
    end

    // Sequence the walk and issue datapath commands
    always_comb begin
        n_state    = r_state;
        n_final    = r_final;
        o_cmd      = '{op: OP_NONE, rd_en: 1'b0, rd_zero: 1'b0, clr_pend: 1'b0};
        o_in_ready = 1'b0;
        finish     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_mode) begin
                        o_cmd.op = OP_LOAD;
                    end else begin
                        o_cmd.op = OP_LATCH;
                        n_state  = i_first ? ST_RESTART : ST_CHECK;
                    end
                end
            end
            ST_RESTART: begin
                o_cmd.op = OP_RESTART;
                if (i_stat.used_zero) begin
                    n_state = ST_CHECK;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_zero = 1'b1;
                    n_state       = ST_ROW0;
                end
            end
            ST_ROW0: begin
                o_cmd.op = OP_TAKE_BPM;
                if (i_stat.used_gt1) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_ROW1;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_ROW1: begin
                o_cmd.op = OP_TAKE_TICK;
                n_state  = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_stat.pending && i_stat.crossing) begin
                    n_state = ST_LOOP;
                end else begin
                    o_cmd.op = OP_SEG_ALL;
                    n_final  = 1'b1;
                    n_state  = ST_DIV;
                end
            end
            ST_LOOP: begin
                priority if (i_stat.reached) begin
                    if (i_stat.nei_ge_used) begin
                        o_cmd.clr_pend = 1'b1;
                        o_cmd.op       = OP_SEG_ALL;
                        n_final        = 1'b1;
                        n_state        = ST_DIV;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                        n_state     = ST_ADV;
                    end
                end else if (i_stat.crossing) begin
                    o_cmd.op = OP_SEG_PART;
                    n_final  = 1'b0;
                    n_state  = ST_DIV;
                end else begin
                    o_cmd.op = OP_SEG_ALL;
                    n_final  = 1'b1;
                    n_state  = ST_DIV;
                end
            end
            ST_ADV: begin
                o_cmd.op = OP_ADVANCE;
                n_state  = ST_ADV_CHK;
            end
            ST_ADV_CHK: begin
                if (i_stat.nei_ge_used) begin
                    o_cmd.clr_pend = 1'b1;
                    o_cmd.op       = OP_SEG_ALL;
                    n_final        = 1'b1;
                    n_state        = ST_DIV;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_TICK;
                end
            end
            ST_TICK: begin
                o_cmd.op = OP_TAKE_TICK;
                n_state  = ST_LOOP;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_stat.div_last) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = r_final ? ST_FINISH : ST_LOOP;
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op = OP_FINISH;
                    finish   = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Drop the result once taken, raise it when a note finishes
    assign n_out_valid = (r_out_valid && !i_out_ready) || finish;
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/tempo_map_tick_to_seconds.sv
// Top level of the tempo-map tick-to-seconds converter.
// Joins tmts_ctrl and tmts_dp; uses tmts_pkg.
//
// Usage: the input channel (i_in_valid / o_in_ready / i_in_item) takes load
// items (mode 0), which write one (tick, bpm) row of the tempo table and give
// no result, and note items (mode 1), which give one result on the output
// channel (o_out_valid / i_out_ready / o_out_item). Registers are written
// through i_cfg_we / i_cfg_idx / i_cfg_data; the user must do so only while
// the block is idle; the block itself does not enforce this. A load item
// is written in the idle state. A note inside one tempo passes a check
// step, a bit-serial division that makes one quotient bit per cycle, an
// accumulate step and a finish step. A track restart first reads table
// row 0 and, with more than one entry, row 1; every tempo change crossed
// adds table walk steps and one more division segment. The block takes no
// new item until the note in hand has finished.
// Reset clears the walk state and the registers to their defaults; the
// tempo table is not cleared and must be loaded before use.
// A stalled receiver keeps the result in the output register; the block
// takes the next item and holds its own result until the register frees.
module tempo_map_tick_to_seconds import tmts_pkg::*; #(
    parameter int TEMPO_ENTRIES = DEF_TEMPO_ENTRIES,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequence the work
    tmts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_in_item.mode),
        .i_first     (i_in_item.first_of_track),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Hold the table and do the arithmetic
    tmts_dp #(
        .TEMPO_ENTRIES (TEMPO_ENTRIES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_item (o_out_item)
    );

endmodule
